>>> rtl/bpr_pkg.sv
// Shared types, constants and the CRC16-MODBUS byte step of the packet receiver.
package bpr_pkg;

	// Size of one payload bank in bytes; frames longer than this are dropped
	localparam int BUFFER_BYTES = 1024;
	// Frame length counter width: holds BUFFER_BYTES itself
	localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
	// Payload bytes kept for command decoding
	localparam int LEAD_BYTES   = 6;
	localparam int PB_W         = 10;
	localparam int CFG_IDX_W    = 3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_INFO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_CHUNK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_START  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_FW     = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_CRC_HI = 3'd1,
		PH_CRC_LO = 3'd2,
		PH_LEN_HI = 3'd3,
		PH_LEN_LO = 3'd4,
		PH_DATA   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INTERNAL = 2'd1,
		ST_BAD_LEN  = 2'd2,
		ST_UNKNOWN  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] op_get_info;
		logic [7:0] op_set_chunk;
		logic [7:0] op_set_start;
		logic [7:0] op_fw_data;
	} cfg_t;

	// Completed frame handed from the parser to the executor
	typedef struct packed {
		logic                            done;
		logic [7:0]                      cmd;
		logic [LEAD_BYTES-1:0][7:0]      lead;
		logic [LEN_W-1:0]                len;
		logic                            crc_ok;
	} frame_t;

	typedef struct packed {
		logic [7:0]      frame_cmd;
		status_t         status;
		logic            crc_ok;
		logic [15:0]     chunk_size_now;
		logic [15:0]     chunk_count_now;
		logic [31:0]     flash_start_now;
		logic [PB_W-1:0] payload_bytes;
	} result_t;

	// Fold one byte into a reflected CRC16-MODBUS
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

>>> rtl/bpr_byte_if.sv
// Received byte channel: valid, ready and one byte.
interface bpr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/bpr_result_if.sv
// Frame result channel: valid, ready and the status of one completed frame.
interface bpr_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_cmd;
	logic [1:0]  status;
	logic        crc_ok;
	logic [15:0] chunk_size_now;
	logic [15:0] chunk_count_now;
	logic [31:0] flash_start_now;
	logic [9:0]  payload_bytes;

	modport source (output valid, output frame_cmd, output status, output crc_ok,
		output chunk_size_now, output chunk_count_now, output flash_start_now,
		output payload_bytes, input ready);
	modport sink   (input valid, input frame_cmd, input status, input crc_ok,
		input chunk_size_now, input chunk_count_now, input flash_start_now,
		input payload_bytes, output ready);
endinterface

>>> rtl/bpr_parser.sv
// Frame parser: header, CRC and length fields, command and leading payload, running CRC.
module bpr_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      rx_byte,
	input  logic [7:0]      header_byte,
	output bpr_pkg::frame_t frame
);
	import bpr_pkg::*;

	phase_t                     phase_q, phase_nx;
	logic [7:0]                 crc_hi_q;
	logic [15:0]                rx_crc_q;
	logic [7:0]                 len_hi_q;
	logic [LEN_W-1:0]           len_q;
	logic [LEN_W-1:0]           pos_q;
	logic [LEN_W-1:0]           pos_inc;
	logic [7:0]                 cmd_q;
	logic [15:0]                crc_q;
	logic [15:0]                crc_nx;
	logic [LEAD_BYTES-1:0][7:0] lead_q, lead_nx;
	logic [15:0]                len_full;
	logic                       len_ok;
	logic                       last_byte;

	// Per-phase strobes
	logic start, cap_crc_hi, cap_crc_lo, cap_len_hi, cap_len_lo, in_data;

	assign len_full  = {len_hi_q, rx_byte};
	assign len_ok    = (len_full != 16'd0) && (len_full <= 16'(BUFFER_BYTES));
	assign pos_inc   = pos_q + LEN_W'(1);
	assign last_byte = (pos_inc == len_q);
	assign crc_nx    = crc_feed(crc_q, rx_byte);

	// Next phase
	always_comb begin
		phase_nx = phase_q;
		if (take) begin
			unique case (phase_q)
				PH_IDLE:   phase_nx = (rx_byte == header_byte) ? PH_CRC_HI : PH_IDLE;
				PH_CRC_HI: phase_nx = PH_CRC_LO;
				PH_CRC_LO: phase_nx = PH_LEN_HI;
				PH_LEN_HI: phase_nx = PH_LEN_LO;
				PH_LEN_LO: phase_nx = len_ok ? PH_DATA : PH_IDLE;
				PH_DATA:   phase_nx = last_byte ? PH_IDLE : PH_DATA;
				default:   phase_nx = PH_IDLE;
			endcase
		end
	end

	// Capture strobes per phase
	always_comb begin
		start      = 1'b0;
		cap_crc_hi = 1'b0;
		cap_crc_lo = 1'b0;
		cap_len_hi = 1'b0;
		cap_len_lo = 1'b0;
		in_data    = 1'b0;
		if (take) begin
			unique case (phase_q)
				PH_IDLE:   start      = (rx_byte == header_byte);
				PH_CRC_HI: cap_crc_hi = 1'b1;
				PH_CRC_LO: cap_crc_lo = 1'b1;
				PH_LEN_HI: cap_len_hi = 1'b1;
				PH_LEN_LO: cap_len_lo = 1'b1;
				PH_DATA:   in_data    = 1'b1;
				default:   start      = 1'b0;
			endcase
		end
	end

	// Leading payload as it stands after this byte
	always_comb begin
		for (int i = 0; i < LEAD_BYTES; i++) begin
			lead_nx[i] = (in_data && pos_q == LEN_W'(i + 1)) ? rx_byte : lead_q[i];
		end
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			crc_hi_q <= '0;
			rx_crc_q <= '0;
			len_hi_q <= '0;
			len_q    <= '0;
			pos_q    <= '0;
			cmd_q    <= '0;
			crc_q    <= CRC_INIT;
			lead_q   <= '0;
		end else begin
			phase_q <= phase_nx;
			if (start) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
			end
			if (cap_crc_hi)
				crc_hi_q <= rx_byte;
			if (cap_crc_lo)
				rx_crc_q <= {crc_hi_q, rx_byte};
			if (cap_len_hi)
				len_hi_q <= rx_byte;
			if (cap_len_lo)
				len_q <= len_full[LEN_W-1:0];
			if (in_data) begin
				crc_q  <= crc_nx;
				pos_q  <= pos_inc;
				lead_q <= lead_nx;
				if (pos_q == '0)
					cmd_q <= rx_byte;
			end
		end
	end

	// Hand the completed frame to the executor
	always_comb begin
		frame.done   = in_data && last_byte;
		frame.cmd    = (pos_q == '0) ? rx_byte : cmd_q;
		frame.lead   = lead_nx;
		frame.len    = len_q;
		frame.crc_ok = (crc_nx == rx_crc_q);
	end

endmodule

>>> rtl/bpr_exec.sv
// Command executor: chunk and address registers, status decode and the result register.
module bpr_exec (
	input  logic             clk,
	input  logic             arst_n,
	input  bpr_pkg::frame_t  frame,
	input  bpr_pkg::cfg_t    cfg,
	input  logic             res_taken,
	output bpr_pkg::result_t res,
	output logic             res_valid
);
	import bpr_pkg::*;

	logic [15:0] size_q, size_nx;
	logic [15:0] count_q, count_nx;
	logic [31:0] start_q, start_nx;
	logic        ready_q, ready_nx;
	status_t     status;
	logic [15:0] p01, p23, p45;
	logic        short_frame;
	logic        res_valid_q;
	result_t     res_s1;

	assign p01         = {frame.lead[0], frame.lead[1]};
	assign p23         = {frame.lead[2], frame.lead[3]};
	assign p45         = {frame.lead[4], frame.lead[5]};
	assign short_frame = frame.len < LEN_W'(5);

	// Decode the command; first matching code wins
	always_comb begin
		size_nx  = size_q;
		count_nx = count_q;
		start_nx = start_q;
		ready_nx = ready_q;
		status   = ST_UNKNOWN;
		priority if (frame.cmd == cfg.op_get_info) begin
			status = ST_OK;
		end else if (frame.cmd == cfg.op_set_chunk) begin
			if (short_frame) begin
				status = ST_BAD_LEN;
			end else begin
				size_nx  = p01;
				count_nx = p23;
				ready_nx = (p01 != 16'd0) && (p01 <= 16'(BUFFER_BYTES));
				status   = ready_nx ? ST_OK : ST_INTERNAL;
			end
		end else if (frame.cmd == cfg.op_set_start) begin
			if (short_frame) begin
				status = ST_BAD_LEN;
			end else begin
				start_nx = {p01, p23};
				if (frame.len >= LEN_W'(7) && p45 != 16'd0)
					size_nx = p45;
				status = ST_OK;
			end
		end else if (frame.cmd == cfg.op_fw_data) begin
			if (!ready_q)
				status = ST_INTERNAL;
			else if (16'(frame.len) - 16'd1 > size_q)
				status = ST_BAD_LEN;
			else
				status = ST_OK;
		end else begin
			status = ST_UNKNOWN;
		end
	end

	// Update registers and load the result on a completed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			count_q     <= '0;
			start_q     <= '0;
			ready_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (frame.done) begin
				size_q      <= size_nx;
				count_q     <= count_nx;
				start_q     <= start_nx;
				ready_q     <= ready_nx;
				res_valid_q <= 1'b1;
			end else if (res_taken) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (frame.done) begin
			res_s1.frame_cmd       <= frame.cmd;
			res_s1.status          <= status;
			res_s1.crc_ok          <= frame.crc_ok;
			res_s1.chunk_size_now  <= size_nx;
			res_s1.chunk_count_now <= count_nx;
			res_s1.flash_start_now <= start_nx;
			res_s1.payload_bytes   <= PB_W'(frame.len - LEN_W'(1));
		end
	end

	assign res       = res_s1;
	assign res_valid = res_valid_q;

endmodule

>>> rtl/bootloader_packet_receiver_unit.sv
// Top level of the bootloader packet receiver: configuration registers, parser and executor.
//
//  channel | dir | handshake       | payload
//  rx      | in  | valid / ready   | rx_byte[7:0]
//  res     | out | valid / ready   | frame_cmd, status, crc_ok, chunk_size_now,
//          |     |                 | chunk_count_now, flash_start_now, payload_bytes
//  cfg     | in  | cfg_we          | cfg_index[2:0], cfg_wdata[7:0]
//
// One byte is taken per cycle; the result of a frame is in the result register the
// cycle after its last byte. Byte intake stalls only while a result sits unread and
// res.ready is low. Reset clears parser, chunk registers and configuration to defaults.
module bootloader_packet_receiver_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	bpr_byte_if.sink                        rx,
	bpr_result_if.source                    res,
	input  logic                            cfg_we,
	input  logic [bpr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_wdata
);
	import bpr_pkg::*;

	cfg_t    cfg_q;
	frame_t  frame;
	result_t result;
	logic    res_valid;
	logic    take;
	logic    res_taken;

	// Accept a byte unless a result waits unread, so that it cannot be overwritten
	assign rx.ready  = !res_valid || res.ready;
	assign take      = rx.valid && rx.ready;
	assign res_taken = res_valid && res.ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte  <= 8'd126;
			cfg_q.op_get_info  <= 8'd1;
			cfg_q.op_set_chunk <= 8'd2;
			cfg_q.op_set_start <= 8'd3;
			cfg_q.op_fw_data   <= 8'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER:   cfg_q.header_byte  <= cfg_wdata;
				CFG_OP_INFO:  cfg_q.op_get_info  <= cfg_wdata;
				CFG_OP_CHUNK: cfg_q.op_set_chunk <= cfg_wdata;
				CFG_OP_START: cfg_q.op_set_start <= cfg_wdata;
				CFG_OP_FW:    cfg_q.op_fw_data   <= cfg_wdata;
				default:      cfg_q              <= cfg_q;
			endcase
		end
	end

	bpr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.rx_byte     (rx.rx_byte),
		.header_byte (cfg_q.header_byte),
		.frame       (frame)
	);

	bpr_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.cfg       (cfg_q),
		.res_taken (res_taken),
		.res       (result),
		.res_valid (res_valid)
	);

	// Drive the result channel
	assign res.valid           = res_valid;
	assign res.frame_cmd       = result.frame_cmd;
	assign res.status          = result.status;
	assign res.crc_ok          = result.crc_ok;
	assign res.chunk_size_now  = result.chunk_size_now;
	assign res.chunk_count_now = result.chunk_count_now;
	assign res.flash_start_now = result.flash_start_now;
	assign res.payload_bytes   = result.payload_bytes;

	// A frame completes only on an accepted byte
	a_done_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |-> take) else $error("frame completed without a byte transaction");

	// A completed frame shows up as a result next cycle
	a_done_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |=> res.valid) else $error("completed frame produced no result");

	// Hold off bytes while a result waits unread
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !rx.ready) else $error("byte taken over unread result");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the bootloader packet receiver: byte streams against a frame predictor.
module tb;
	import bpr_pkg::*;

	localparam logic [15:0] MODBUS_SEED = 16'hFFFF;
	localparam logic [15:0] MODBUS_POLY = 16'hA001;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;

	bpr_byte_if rx_ch ();
	bpr_result_if res_ch ();

	bootloader_packet_receiver_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Stimulus bookkeeping
	logic [7:0] byte_queue[$];
	logic [7:0] body_bytes[$];
	int bytes_pushed = 0;
	int bytes_taken = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int mismatch_count = 0;
	// Chunk size the generator expects the block to hold; steers firmware frame lengths
	logic [15:0] gen_chunk = '0;

	// Predictor state, starting from the reset values
	cfg_t model_cfg = '{header_byte: 8'd126, op_get_info: 8'd1, op_set_chunk: 8'd2,
		op_set_start: 8'd3, op_fw_data: 8'd4};
	phase_t frame_phase = PH_IDLE;
	logic [15:0] got_crc = '0;
	logic [15:0] frame_len = '0;
	logic [15:0] byte_pos = '0;
	logic [7:0] held_cmd = '0;
	logic [15:0] calc_crc = MODBUS_SEED;
	logic [7:0] lead_bytes[LEAD_BYTES] = '{default: 8'h00};
	logic [15:0] pred_size = '0;
	logic [15:0] chunk_count = '0;
	logic [31:0] flash_start = '0;
	logic chunk_armed = 1'b0;
	result_t expected_frames[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	initial begin
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
	end

	// Reflected CRC16 over one byte
	function automatic logic [15:0] modbus_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ MODBUS_POLY) : (c >> 1);
		return c;
	endfunction

	// Execute a completed frame against the chunk and address registers
	function automatic status_t run_frame();
		logic [15:0] sz;
		if (held_cmd == model_cfg.op_get_info)
			return ST_OK;
		if (held_cmd == model_cfg.op_set_chunk) begin
			if (frame_len < 16'd5)
				return ST_BAD_LEN;
			pred_size = {lead_bytes[0], lead_bytes[1]};
			chunk_count = {lead_bytes[2], lead_bytes[3]};
			chunk_armed = (pred_size != 16'd0) && (pred_size <= 16'(BUFFER_BYTES));
			return chunk_armed ? ST_OK : ST_INTERNAL;
		end
		if (held_cmd == model_cfg.op_set_start) begin
			if (frame_len < 16'd5)
				return ST_BAD_LEN;
			flash_start = {lead_bytes[0], lead_bytes[1], lead_bytes[2], lead_bytes[3]};
			sz = {lead_bytes[4], lead_bytes[5]};
			if (frame_len >= 16'd7 && sz != 16'd0)
				pred_size = sz;
			return ST_OK;
		end
		if (held_cmd == model_cfg.op_fw_data) begin
			if (!chunk_armed)
				return ST_INTERNAL;
			if (frame_len - 16'd1 > pred_size)
				return ST_BAD_LEN;
			return ST_OK;
		end
		return ST_UNKNOWN;
	endfunction

	// Advance the frame parser by one accepted byte; queue a result when a frame completes
	task automatic take_byte(input logic [7:0] b);
		result_t r;
		case (frame_phase)
			PH_IDLE: begin
				if (b == model_cfg.header_byte) begin
					byte_pos = '0;
					calc_crc = MODBUS_SEED;
					frame_phase = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				got_crc = {b, 8'h00};
				frame_phase = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				got_crc[7:0] = b;
				frame_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				frame_len = {b, 8'h00};
				frame_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				frame_len[7:0] = b;
				// drop empty and oversize frames
				if (frame_len != 16'd0 && frame_len <= 16'(BUFFER_BYTES))
					frame_phase = PH_DATA;
				else
					frame_phase = PH_IDLE;
			end
			PH_DATA: begin
				calc_crc = modbus_step(calc_crc, b);
				if (byte_pos == 16'd0)
					held_cmd = b;
				else if (byte_pos <= 16'(LEAD_BYTES))
					lead_bytes[byte_pos - 16'd1] = b;
				byte_pos++;
				if (byte_pos == frame_len) begin
					frame_phase = PH_IDLE;
					r.status = run_frame();
					r.frame_cmd = held_cmd;
					r.crc_ok = (calc_crc == got_crc);
					r.chunk_size_now = pred_size;
					r.chunk_count_now = chunk_count;
					r.flash_start_now = flash_start;
					r.payload_bytes = PB_W'(frame_len - 16'd1);
					expected_frames.push_back(r);
				end
			end
			default: frame_phase = PH_IDLE;
		endcase
	endtask

	// Driver: one transaction per accepted byte, valid held until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready) begin
				take_byte(rx_ch.rx_byte);
				bytes_taken++;
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (byte_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= byte_queue.pop_front();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_field(input string field, input logic [31:0] want_v,
		input logic [31:0] got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
	endtask

	// Compare one result transaction with the oldest pending frame
	task automatic check_result();
		result_t want;
		if (expected_frames.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result with no frame pending: cmd 0x%0h status %0d",
					res_ch.frame_cmd, res_ch.status);
			return;
		end
		want = expected_frames.pop_front();
		if (res_ch.frame_cmd !== want.frame_cmd)
			flag_field("frame_cmd", want.frame_cmd, res_ch.frame_cmd);
		if (res_ch.status !== want.status)
			flag_field("status", want.status, res_ch.status);
		if (res_ch.crc_ok !== want.crc_ok)
			flag_field("crc_ok", want.crc_ok, res_ch.crc_ok);
		if (res_ch.chunk_size_now !== want.chunk_size_now)
			flag_field("chunk_size_now", want.chunk_size_now, res_ch.chunk_size_now);
		if (res_ch.chunk_count_now !== want.chunk_count_now)
			flag_field("chunk_count_now", want.chunk_count_now, res_ch.chunk_count_now);
		if (res_ch.flash_start_now !== want.flash_start_now)
			flag_field("flash_start_now", want.flash_start_now, res_ch.flash_start_now);
		if (res_ch.payload_bytes !== want.payload_bytes)
			flag_field("payload_bytes", want.payload_bytes, res_ch.payload_bytes);
	endtask

	// Monitor: random back-pressure on the result channel
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				check_result();
			res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		byte_queue.push_back(b);
		bytes_pushed++;
	endtask

	task automatic fill_body(input int plen);
		repeat (plen) body_bytes.push_back(8'($urandom));
	endtask

	// Wrap the staged body into a full frame; optionally corrupt the CRC
	task automatic queue_frame(input logic [7:0] cmd, input bit bad_crc);
		logic [15:0] crc;
		logic [15:0] flen;
		crc = modbus_step(MODBUS_SEED, cmd);
		foreach (body_bytes[i])
			crc = modbus_step(crc, body_bytes[i]);
		if (bad_crc)
			crc ^= 16'(1 << $urandom_range(15));
		flen = 16'(body_bytes.size() + 1);
		queue_byte(model_cfg.header_byte);
		queue_byte(crc[15:8]);
		queue_byte(crc[7:0]);
		queue_byte(flen[15:8]);
		queue_byte(flen[7:0]);
		queue_byte(cmd);
		foreach (body_bytes[i])
			queue_byte(body_bytes[i]);
		body_bytes.delete();
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_HEADER:   model_cfg.header_byte = val;
			CFG_OP_INFO:  model_cfg.op_get_info = val;
			CFG_OP_CHUNK: model_cfg.op_set_chunk = val;
			CFG_OP_START: model_cfg.op_set_start = val;
			CFG_OP_FW:    model_cfg.op_fw_data = val;
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [7:0] hdr, input logic [7:0] info,
		input logic [7:0] chunk, input logic [7:0] start, input logic [7:0] fw);
		write_reg(CFG_HEADER, hdr);
		write_reg(CFG_OP_INFO, info);
		write_reg(CFG_OP_CHUNK, chunk);
		write_reg(CFG_OP_START, start);
		write_reg(CFG_OP_FW, fw);
	endtask

	// Mostly well-formed frames with random content, plus stray bytes and broken frames
	task automatic queue_random_stream(input int budget);
		int stop_at;
		int pick;
		int plen;
		logic [7:0] cmd;
		logic [15:0] sz;
		stop_at = bytes_pushed + budget;
		while (bytes_pushed < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				// stray bytes between frames
				repeat ($urandom_range(3, 1)) queue_byte(8'($urandom));
			end else if (pick < 10) begin
				// empty or oversize length: frame is dropped
				sz = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, BUFFER_BYTES + 1));
				queue_byte(model_cfg.header_byte);
				queue_byte(8'($urandom));
				queue_byte(8'($urandom));
				queue_byte(sz[15:8]);
				queue_byte(sz[7:0]);
			end else if (pick < 12) begin
				// cut-off preamble: the following bytes complete it
				queue_byte(model_cfg.header_byte);
				repeat ($urandom_range(3, 1)) queue_byte(8'($urandom));
			end else begin
				pick = $urandom_range(99);
				if (pick < 8)
					sz = '0;
				else if (pick < 14)
					sz = 16'(BUFFER_BYTES);
				else if (pick < 20)
					sz = 16'(BUFFER_BYTES + 1);
				else if (pick < 26)
					sz = 16'($urandom);
				else
					sz = 16'($urandom_range(48, 1));
				pick = $urandom_range(99);
				if (pick < 12) begin
					cmd = model_cfg.op_get_info;
					fill_body($urandom_range(4));
				end else if (pick < 36) begin
					cmd = model_cfg.op_set_chunk;
					plen = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(6, 4);
					fill_body(plen);
					if (plen >= 4) begin
						body_bytes[0] = sz[15:8];
						body_bytes[1] = sz[7:0];
						gen_chunk = sz;
					end
				end else if (pick < 52) begin
					cmd = model_cfg.op_set_start;
					plen = $urandom_range(9);
					fill_body(plen);
					if ($urandom_range(2) == 0)
						sz = '0;
					if (plen >= 6) begin
						body_bytes[4] = sz[15:8];
						body_bytes[5] = sz[7:0];
						if (sz != 16'd0)
							gen_chunk = sz;
					end
				end else if (pick < 88) begin
					cmd = model_cfg.op_fw_data;
					if (gen_chunk == 16'd0 || gen_chunk > 16'(BUFFER_BYTES))
						plen = $urandom_range(8);
					else if (gen_chunk < 16'd40 && $urandom_range(4) == 0)
						plen = int'(gen_chunk) + 1;
					else
						plen = $urandom_range(gen_chunk < 16'd40 ? int'(gen_chunk) : 40);
					fill_body(plen);
				end else begin
					cmd = 8'($urandom);
					fill_body($urandom_range(6));
				end
				queue_frame(cmd, $urandom_range(99) < 8);
			end
		end
	endtask

	// Bring the parser back to idle and let every pending result drain
	task automatic settle();
		while (bytes_taken != bytes_pushed) @(posedge clk);
		while (frame_phase != PH_IDLE) begin
			if (frame_phase == PH_DATA)
				repeat (int'(frame_len - byte_pos)) queue_byte(8'($urandom));
			else if (frame_phase == PH_LEN_LO)
				queue_byte(frame_len == 16'd0 ? 8'h00 : 8'hFF);
			else
				queue_byte(8'h00);
			while (bytes_taken != bytes_pushed) @(posedge clk);
		end
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 38;
		snk_stall_pct = 66;

		// Directed frames at the reset configuration
		queue_frame(model_cfg.op_get_info, 1'b0);
		// firmware before any chunk setup, with a corrupted CRC
		queue_frame(model_cfg.op_fw_data, 1'b1);
		// zero length is dropped, then a stray byte in idle
		queue_byte(model_cfg.header_byte);
		queue_byte(8'hFF);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_byte(8'h00);
		queue_byte(8'h00);
		// header value inside the payload is plain data
		body_bytes = '{8'h00, 8'h7E, 8'hFF, 8'hFF};
		queue_frame(model_cfg.op_set_chunk, 1'b0);
		body_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h10};
		queue_frame(model_cfg.op_set_start, 1'b0);
		body_bytes = '{8'h00, 8'hFF};
		queue_frame(model_cfg.op_fw_data, 1'b0);
		queue_frame(8'hFF, 1'b0);
		body_bytes = '{8'h12};
		queue_frame(model_cfg.op_set_chunk, 1'b0);
		body_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
		queue_frame(model_cfg.op_set_chunk, 1'b0);
		gen_chunk = '0;
		queue_random_stream(190);
		settle();

		// Extreme header and command codes
		write_all_regs(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F);
		queue_random_stream(190);
		settle();

		src_idle_pct = 66;
		snk_stall_pct = 38;

		// Colliding command codes: the earlier command wins
		write_all_regs(8'h00, 8'h05, 8'h05, 8'h06, 8'h06);
		queue_random_stream(160);
		settle();

		write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		queue_random_stream(160);
		settle();

		src_idle_pct = 0;
		snk_stall_pct = 0;

		// Back to the usual codes; chunk store at its largest, then a length one past the limit
		write_all_regs(8'd126, 8'd1, 8'd2, 8'd3, 8'd4);
		body_bytes = '{8'h04, 8'h00, 8'hFF, 8'hFF};
		queue_frame(model_cfg.op_set_chunk, 1'b0);
		queue_byte(model_cfg.header_byte);
		queue_byte(8'h00);
		queue_byte(8'h00);
		queue_byte(8'h04);
		queue_byte(8'h01);
		gen_chunk = 16'(BUFFER_BYTES);
		queue_random_stream(160);
		settle();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_frames.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/bpr_pkg.sv
rtl/bpr_byte_if.sv
rtl/bpr_result_if.sv
rtl/bpr_parser.sv
rtl/bpr_exec.sv
rtl/bootloader_packet_receiver_unit.sv
tb/tb.sv
